>>> src/sfade_pkg.sv
// shared constants, codes and types of the smootherstep light fade core
`timescale 1ns / 1ps

package sfade_pkg;

  localparam int CHANNELS      = 4;
  localparam int LEVEL_BITS    = 16;
  localparam int MAX_CHANNELS  = 4;
  localparam int SLOT_BITS     = 16;
  localparam int LEVELS_BITS   = MAX_CHANNELS * SLOT_BITS;
  localparam int TIME_BITS     = 32;
  localparam int Q_BITS        = 16;
  localparam int X_BITS        = Q_BITS + 1;
  localparam int DIV_STAGES    = Q_BITS;
  localparam int A_BITS        = 20;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam int IN_DATA_BITS  = 32;
  localparam int OFS_PROG      = LEVELS_BITS;
  localparam int OFS_FIN       = OFS_PROG + Q_BITS;
  localparam int OFS_CONT      = OFS_FIN + 1;
  localparam int OFS_END       = OFS_CONT + 1;
  localparam int OUT_USED      = OFS_END + LEVELS_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED + 7) / 8) * 8;

  localparam logic [X_BITS-1:0]   QONE   = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [Q_BITS-1:0]   Q_FULL = {Q_BITS{1'b1}};
  localparam logic [A_BITS-1:0]   A_BASE = A_BITS'(15) << Q_BITS;
  localparam logic [A_BITS:0]     C_BASE = (A_BITS + 1)'(10) << Q_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_TIME    = 3'd0,
    CFG_DURATION      = 3'd1,
    CFG_FLASH_MODE    = 3'd2,
    CFG_START_LEVELS  = 3'd3,
    CFG_TARGET_LEVELS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              vld;
    logic              done;
    logic [Q_BITS-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic              vld;
    logic              done;
    logic [Q_BITS-1:0] prog;
    logic [X_BITS-1:0] v;
  } shape_res_t;

endpackage

>>> src/smootherstep_light_fade_core.sv
// top level: config registers, divider, shaper, channel lanes and output merge
// an accepted input passes the divider, shaper, lane and output registers to m_axis_tvalid_o
// throughput: one transaction per cycle while the skid entry is empty, set by the divider pipeline
// a two-entry output (register plus skid) keeps accepting while one result waits
// reset: asynchronous active low, clears config registers and all valid flags
`timescale 1ns / 1ps

module smootherstep_light_fade_core import sfade_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // now_ms[31:0]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // level_ch0, level_ch1, level_ch2, level_ch3, progress, finished, continuous,
  // end_levels, zero pad
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o
);

  logic [TIME_BITS-1:0]   start_time_q;
  logic [TIME_BITS-1:0]   duration_q;
  logic                   flash_q;
  logic [LEVELS_BITS-1:0] start_lv_q;
  logic [LEVELS_BITS-1:0] target_lv_q;

  logic                   ce;
  div_res_t               div_res;
  shape_res_t             shape_res;
  logic [LEVEL_BITS-1:0]  lane_lvl [MAX_CHANNELS];

  logic [1:0]             lvld_q;
  logic [1:0]             ldone_q;
  logic [Q_BITS-1:0]      lprog_q [2];

  logic [OUT_DATA_BITS-1:0] pipe_data;
  logic                     out_vld_q;
  logic [OUT_DATA_BITS-1:0] out_data_q;
  logic                     skid_vld_q;
  logic [OUT_DATA_BITS-1:0] skid_data_q;
  logic                     out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      duration_q   <= '0;
      flash_q      <= 1'b0;
      start_lv_q   <= '0;
      target_lv_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_TIME:    start_time_q <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_DURATION:      duration_q   <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_FLASH_MODE:    flash_q      <= cfg_wdata_i[0];
        CFG_START_LEVELS:  start_lv_q   <= cfg_wdata_i[LEVELS_BITS-1:0];
        CFG_TARGET_LEVELS: target_lv_q  <= cfg_wdata_i[LEVELS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ce              = !skid_vld_q;
  assign s_axis_tready_o = ce;

  sfade_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .vld_i   (s_axis_tvalid_i),
    .now_i   (s_axis_tdata_i[TIME_BITS-1:0]),
    .start_i (start_time_q),
    .dur_i   (duration_q),
    .res_o   (div_res)
  );

  sfade_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .div_i  (div_res),
    .res_o  (shape_res)
  );

  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_on
      sfade_lane u_lane (
        .clk_i    (clk_i),
        .ce_i     (ce),
        .start_i  (start_lv_q[SLOT_BITS*ch +: LEVEL_BITS]),
        .target_i (target_lv_q[SLOT_BITS*ch +: LEVEL_BITS]),
        .v_i      (shape_res.v),
        .level_o  (lane_lvl[ch])
      );
    end else begin : g_off
      assign lane_lvl[ch] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q <= '0;
    end else if (ce) begin
      lvld_q <= {lvld_q[0], shape_res.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      ldone_q    <= {ldone_q[0], shape_res.done};
      lprog_q[0] <= shape_res.prog;
      lprog_q[1] <= lprog_q[0];
    end
  end

  // merge lanes and sideband into one result
  always_comb begin
    pipe_data = '0;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (ch < CHANNELS) begin
        pipe_data[SLOT_BITS*ch +: SLOT_BITS] = flash_q ?
          SLOT_BITS'(target_lv_q[SLOT_BITS*ch +: LEVEL_BITS]) : SLOT_BITS'(lane_lvl[ch]);
        pipe_data[OFS_END + SLOT_BITS*ch +: SLOT_BITS] = flash_q ?
          SLOT_BITS'(start_lv_q[SLOT_BITS*ch +: LEVEL_BITS]) :
          SLOT_BITS'(target_lv_q[SLOT_BITS*ch +: LEVEL_BITS]);
      end
    end
    pipe_data[OFS_PROG +: Q_BITS] = lprog_q[1];
    pipe_data[OFS_FIN]            = ldone_q[1];
    pipe_data[OFS_CONT]           = !flash_q;
  end

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= lvld_q[1];
      end
    end else if (lvld_q[1] && ce) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_vld_q ? skid_data_q : pipe_data;
    end else if (lvld_q[1] && ce) begin
      skid_data_q <= pipe_data;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> src/sfade_div.sv
// pipelined restoring divider for elapsed * 2^16 / duration, one quotient bit per stage
`timescale 1ns / 1ps

module sfade_div import sfade_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ce_i,
  input  logic                 vld_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] start_i,
  input  logic [TIME_BITS-1:0] dur_i,
  output div_res_t             res_o
);

  logic [DIV_STAGES:0]  vld_q;
  logic [DIV_STAGES:0]  done_q;
  logic [TIME_BITS-1:0] rem_q [DIV_STAGES+1];
  logic [Q_BITS-1:0]    quo_q [DIV_STAGES+1];
  logic [TIME_BITS-1:0] rem_d [DIV_STAGES+1];
  logic [Q_BITS-1:0]    quo_d [DIV_STAGES+1];
  logic [TIME_BITS-1:0] elapsed;
  logic                 done_d;

  assign elapsed = now_i - start_i;
  assign done_d  = (dur_i == '0) || (elapsed >= dur_i);

  always_comb begin
    logic [TIME_BITS:0] shifted;
    logic [TIME_BITS:0] diff;
    logic               ge;
    rem_d[0] = elapsed;
    quo_d[0] = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      shifted  = {rem_q[k-1], 1'b0};
      diff     = shifted - {1'b0, dur_i};
      ge       = shifted >= {1'b0, dur_i};
      rem_d[k] = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quo_d[k] = {quo_q[k-1][Q_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[DIV_STAGES-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      done_q <= {done_q[DIV_STAGES-1:0], done_d};
      for (int k = 0; k <= DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign res_o.vld  = vld_q[DIV_STAGES];
  assign res_o.done = done_q[DIV_STAGES];
  assign res_o.q    = quo_q[DIV_STAGES];

endmodule

>>> src/sfade_poly.sv
// four-stage smootherstep shaper 6x^5-15x^4+10x^3 in q1.16
`timescale 1ns / 1ps

module sfade_poly import sfade_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ce_i,
  input  div_res_t   div_i,
  output shape_res_t res_o
);

  localparam int XA_BITS = X_BITS + A_BITS;
  localparam int XX_BITS = 2 * X_BITS;

  logic [3:0]              vld_q;
  logic [3:0]              done_q;
  logic [Q_BITS-1:0]       prog_q [4];

  logic [X_BITS-1:0]       x_in;
  logic [A_BITS-1:0]       a_d;
  logic [X_BITS-1:0]       x1_q;
  logic [XA_BITS-1:0]      xa_q;
  logic [XX_BITS-1:0]      xx_q;

  logic [A_BITS:0]         c_full;
  logic [A_BITS-1:0]       c2_q;
  logic [XX_BITS-1:0]      x3p_q;

  logic [XA_BITS-1:0]      vp_q;
  logic [XA_BITS-Q_BITS-1:0] vs;
  logic [X_BITS-1:0]       v_q;

  assign x_in   = div_i.done ? QONE : {1'b0, div_i.q};
  assign a_d    = A_BASE - A_BITS'(x_in) * A_BITS'(6);
  assign c_full = C_BASE - xa_q[XA_BITS-1:Q_BITS];
  assign vs     = vp_q[XA_BITS-1:Q_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[2:0], div_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      done_q    <= {done_q[2:0], div_i.done};
      prog_q[0] <= div_i.done ? Q_FULL : div_i.q;
      for (int k = 1; k < 4; k++) begin
        prog_q[k] <= prog_q[k-1];
      end
      x1_q  <= x_in;
      xa_q  <= XA_BITS'(x_in) * XA_BITS'(a_d);
      xx_q  <= XX_BITS'(x_in) * XX_BITS'(x_in);
      c2_q  <= c_full[A_BITS-1:0];
      x3p_q <= XX_BITS'(xx_q[XX_BITS-2:Q_BITS]) * XX_BITS'(x1_q);
      vp_q  <= XA_BITS'(x3p_q[XX_BITS-2:Q_BITS]) * XA_BITS'(c2_q);
      v_q   <= (vs > (XA_BITS - Q_BITS)'(QONE)) ? QONE : vs[X_BITS-1:0];
    end
  end

  assign res_o.vld  = vld_q[3];
  assign res_o.done = done_q[3];
  assign res_o.prog = prog_q[3];
  assign res_o.v    = v_q;

endmodule

>>> src/sfade_lane.sv
// one channel lane: interpolates from start to target by the shaped progress
`timescale 1ns / 1ps

module sfade_lane import sfade_pkg::*; (
  input  logic                  clk_i,
  input  logic                  ce_i,
  input  logic [LEVEL_BITS-1:0] start_i,
  input  logic [LEVEL_BITS-1:0] target_i,
  input  logic [X_BITS-1:0]     v_i,
  output logic [LEVEL_BITS-1:0] level_o
);

  localparam int P_BITS = LEVEL_BITS + X_BITS;

  logic                  up_q;
  logic [LEVEL_BITS-1:0] mag_q;
  logic [LEVEL_BITS-1:0] start_q;
  logic [P_BITS-1:0]     prod_q;
  logic [LEVEL_BITS-1:0] step;
  logic [LEVEL_BITS-1:0] level_q;

  // the user must keep levels static while items are in flight; the lane does not enforce it
  always_ff @(posedge clk_i) begin
    up_q    <= target_i >= start_i;
    mag_q   <= (target_i >= start_i) ? (target_i - start_i) : (start_i - target_i);
    start_q <= start_i;
  end

  assign step = prod_q[P_BITS-2:Q_BITS];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prod_q  <= P_BITS'(mag_q) * P_BITS'(v_i);
      level_q <= up_q ? (start_q + step) : (start_q - step);
    end
  end

  assign level_o = level_q;

endmodule

>>> src/sfade_chk.sv
// port-level checker for the smootherstep light fade core and its bind
`timescale 1ns / 1ps

module sfade_chk import sfade_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // input only stalls after the output was held back
  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without an output stall");

  // a finished transition reports full progress
  a_fin_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OFS_FIN] |-> m_axis_tdata_o[OFS_PROG +: Q_BITS] == Q_FULL)
    else $error("finished without full progress");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_BITS-1:OUT_USED] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind smootherstep_light_fade_core sfade_chk u_sfade_chk (.*);
